>>> src/udiv64_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udiv64_pkg
// shared types and constants for the pipelined unsigned divider
// ----------------------------------------------------------------------------
package udiv64_pkg;

    // width of every operand and result port
    localparam int unsigned FIELD_W = 64;

    // control bits that travel with each request through the stages
    typedef struct packed {
        logic valid;
        logic den_zero;
    } step_ctrl_t;

endpackage : udiv64_pkg
`default_nettype wire

>>> src/udiv64_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udiv64_step
// one registered restoring division step: shift, trial subtract, restore
// ----------------------------------------------------------------------------
module udiv64_step
    import udiv64_pkg::*;
#(
    parameter int unsigned WIDTH = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire step_ctrl_t       ctrl_in,
    input  wire logic [WIDTH-1:0] part_in,
    input  wire logic [WIDTH-1:0] rq_in,
    input  wire logic [WIDTH-1:0] den_in,
    output step_ctrl_t            ctrl_out,
    output logic      [WIDTH-1:0] part_out,
    output logic      [WIDTH-1:0] rq_out,
    output logic      [WIDTH-1:0] den_out
);

    step_ctrl_t       ctrl_reg;
    logic [WIDTH-1:0] part_reg;
    logic [WIDTH-1:0] part_next;
    logic [WIDTH-1:0] rq_reg;
    logic [WIDTH-1:0] rq_next;
    logic [WIDTH-1:0] den_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             take;

    // partial remainder with the shifted-out bit kept on top
    assign trial = {part_in, rq_in[WIDTH-1]};
    assign diff  = trial - {1'b0, den_in};
    // no borrow means the extended remainder is at least the divisor
    assign take  = ~diff[WIDTH];

    always_comb
    begin
        if (take)
        begin
            part_next = diff[WIDTH-1:0];
        end
        else
        begin
            part_next = trial[WIDTH-1:0];
        end
        // dividend bits leave at the top, quotient bits enter at the bottom
        rq_next = {rq_in[WIDTH-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        rq_reg   <= rq_next;
        den_reg  <= den_in;
    end

    assign ctrl_out = ctrl_reg;
    assign part_out = part_reg;
    assign rq_out   = rq_reg;
    assign den_out  = den_reg;

endmodule : udiv64_step
`default_nettype wire

>>> src/unsigned_divider_64_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_divider_64_top
// fully pipelined unsigned restoring divider, one request per cycle
// ----------------------------------------------------------------------------
// usage: pulse start with dividend and divisor; a request is taken at every
// clock edge where start is high, since busy stays low (the pipeline never
// stalls, so back-to-back requests are fine). results appear on quotient and
// remainder marked by done for one cycle, in request order. the receiver
// must take each result in that cycle. the pipeline is one register stage per
// quotient bit (each stage is one wide subtract and compare) plus the output
// register. a zero divisor returns zero quotient and zero remainder with no
// flag. DATA_WIDTH below 64 uses only the low bits of the operands and
// zero-fills the results; values above 64 act as 64.
// ----------------------------------------------------------------------------
module unsigned_divider_64_top
    import udiv64_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [FIELD_W-1:0] dividend,
    input  wire logic [FIELD_W-1:0] divisor,
    output logic                    done,
    output logic      [FIELD_W-1:0] quotient,
    output logic      [FIELD_W-1:0] remainder
);

    // working width of the datapath
    localparam int unsigned DIV_W = (DATA_WIDTH > FIELD_W) ? FIELD_W : DATA_WIDTH;
    // cycles from request to result
    localparam int unsigned LAT   = DIV_W + 1;

    // stage boundaries: index 0 is the request, index DIV_W the last step
    step_ctrl_t       ctrl_pipe [DIV_W+1];
    logic [DIV_W-1:0] part_pipe [DIV_W+1];
    logic [DIV_W-1:0] rq_pipe   [DIV_W+1];
    logic [DIV_W-1:0] den_pipe  [DIV_W+1];

    logic               done_reg;
    logic [FIELD_W-1:0] quotient_reg;
    logic [FIELD_W-1:0] quotient_next;
    logic [FIELD_W-1:0] remainder_reg;
    logic [FIELD_W-1:0] remainder_next;

    // no back-pressure anywhere, so a request is always welcome
    assign busy = 1'b0;

    // request enters step 0; the zero-divisor check is done once up front
    assign ctrl_pipe[0] = {start & ~busy, (divisor[DIV_W-1:0] == '0)};
    assign part_pipe[0] = '0;
    assign rq_pipe[0]   = dividend[DIV_W-1:0];
    assign den_pipe[0]  = divisor[DIV_W-1:0];

    // one registered step per quotient bit, msb first
    for (genvar g = 0; g < DIV_W; g++)
    begin : g_step
        udiv64_step #(
            .WIDTH (DIV_W)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_pipe[g]),
            .part_in  (part_pipe[g]),
            .rq_in    (rq_pipe[g]),
            .den_in   (den_pipe[g]),
            .ctrl_out (ctrl_pipe[g+1]),
            .part_out (part_pipe[g+1]),
            .rq_out   (rq_pipe[g+1]),
            .den_out  (den_pipe[g+1])
        );
    end

    // output stage: zero-divisor override and zero fill to port width
    always_comb
    begin
        quotient_next  = '0;
        remainder_next = '0;
        if (!ctrl_pipe[DIV_W].den_zero)
        begin
            quotient_next[DIV_W-1:0]  = rq_pipe[DIV_W];
            remainder_next[DIV_W-1:0] = part_pipe[DIV_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_pipe[DIV_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        quotient_reg  <= quotient_next;
        remainder_reg <= remainder_next;
    end

    assign done      = done_reg;
    assign quotient  = quotient_reg;
    assign remainder = remainder_reg;

`ifndef SYNTHESIS
    // every result traces back to a request exactly one latency earlier
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching request");

    // a nonzero divisor leaves a remainder below it
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(divisor[DIV_W-1:0], LAT) != '0))
            |-> (remainder[DIV_W-1:0] < $past(divisor[DIV_W-1:0], LAT)))
        else $error("remainder not below divisor");

    // a zero divisor gives zero results
    a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(divisor[DIV_W-1:0], LAT) == '0))
            |-> ((quotient == '0) && (remainder == '0)))
        else $error("zero divisor gave nonzero result");
`endif

endmodule : unsigned_divider_64_top
`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pipelined 64-bit unsigned divider: a directed
// set of edge-case divisions followed by random requests with random start
// gaps; a scoreboard predicts quotient and remainder bit by bit with its own
// restoring divide and checks each done strobe in order
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import udiv64_pkg::*;

    // drain past the full pipeline depth so that stray results still show up
    localparam int unsigned DRAIN_CYCLES = FIELD_W + 16;
    localparam int unsigned WAIT_LIMIT   = 4000;
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned CALM_ITEMS   = 80;     // tail of the run with no start gaps
    localparam int unsigned MAX_REPORTS  = 10;

    typedef logic [FIELD_W-1:0] word_t;

    // one expected answer of the divider
    typedef struct packed {
        word_t quotient;
        word_t remainder;
    } div_answer_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts each accepted request and checks results in order
    // ------------------------------------------------------------------------
    class div_scoreboard;
        div_answer_t answers_due[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        // restoring division, msb first, with the bit shifted out of the
        // partial remainder kept as a carry
        function div_answer_t restoring_divide(word_t num, word_t den);
            div_answer_t ans;
            word_t       part;
            word_t       bits;
            logic        carry;
            part = '0;
            bits = num;
            ans  = '0;
            if (den == '0)
                return ans;
            for (int step = 0; step < FIELD_W; step++)
            begin
                carry        = part[FIELD_W-1];
                part         = {part[FIELD_W-2:0], bits[FIELD_W-1]};
                bits         = bits << 1;
                ans.quotient = ans.quotient << 1;
                if (carry || part >= den)
                begin
                    part            = part - den;
                    ans.quotient[0] = 1'b1;
                end
            end
            ans.remainder = part;
            return ans;
        endfunction

        function void note_request(word_t num, word_t den);
            answers_due.push_back(restoring_divide(num, den));
        endfunction

        function void check_result(word_t quo, word_t rem);
            div_answer_t want;
            checked++;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result: quotient=%h remainder=%h",
                             $realtime, quo, rem);
                return;
            end
            want = answers_due.pop_front();
            if (want.quotient !== quo || want.remainder !== rem)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] mismatch: quo exp=%h got=%h, rem exp=%h got=%h",
                             $realtime, want.quotient, quo, want.remainder, rem);
            end
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut signals and instance
    // ------------------------------------------------------------------------
    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    word_t dividend;
    word_t divisor;
    logic  done;
    word_t quotient;
    word_t remainder;

    unsigned_divider_64_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    div_scoreboard sb = new();

    // coverage tallies for the closing summary
    int unsigned n_requests  = 0;
    int unsigned n_zero_den  = 0;
    int unsigned n_top_den   = 0;
    int unsigned n_small_quo = 0;

    // ------------------------------------------------------------------------
    // clock: 20 ns period
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // watchdog: far beyond the slowest legal run
    // ------------------------------------------------------------------------
    initial
    begin
        #2ms;
        $display("timeout waiting for the divider");
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // monitor: requests and results are sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a request is taken on any edge with start high and busy low
            if (start && !busy)
            begin
                sb.note_request(dividend, divisor);
                n_requests++;
                if (divisor == '0)
                    n_zero_den++;
                if (divisor[FIELD_W-1])
                    n_top_den++;
                if (divisor > dividend)
                    n_small_quo++;
            end
            // results last one cycle and cannot be held off
            if (done)
                sb.check_result(quotient, remainder);
        end
    end

    // ------------------------------------------------------------------------
    // driver: called just after a falling edge, returns just after the
    // falling edge that follows acceptance, with start still high so that a
    // following request can go back to back
    // ------------------------------------------------------------------------
    task automatic send_division(input word_t num, input word_t den);
        start    <= 1'b1;
        dividend <= num;
        divisor  <= den;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // drop start for a random gap before the next request
    task automatic start_gap();
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
    endtask

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // random request shaped to spread quotient sizes and hit the corners
    task automatic send_random();
        word_t num;
        word_t den;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        num  = rand_word();
        den  = rand_word();
        if (pick < 30)
            den = den >> $urandom_range(0, FIELD_W - 1);     // any quotient width
        else if (pick < 45)
            num = num >> $urandom_range(0, FIELD_W - 1);     // mostly divisor above dividend
        else if (pick < 55)
        begin
            den = den | {1'b1, {(FIELD_W-1){1'b0}}};         // top bit set, carry path
            num = num | {1'b1, {(FIELD_W-1){1'b0}}};
        end
        else if (pick < 62)
            den = '0;                                        // zero divisor
        else if (pick < 70)
            den = word_t'($urandom_range(1, 16));            // tiny divisors, big quotients
        else if (pick < 76)
            num = den;                                       // equal operands
        else if (pick < 82)
            num = den - word_t'($urandom_range(0, 3));       // at or just below the divisor
        send_division(num, den);
    endtask

    // edge cases: extremes, zero divisor, divisor above dividend, carry path
    task automatic send_directed();
        word_t top;
        word_t ones;
        top  = {1'b1, {(FIELD_W-1){1'b0}}};
        ones = '1;
        send_division('0, '0);
        send_division(ones, '0);
        send_division('0, word_t'(1));
        send_division(ones, word_t'(1));
        send_division(ones, ones);
        send_division('0, ones);
        send_division(word_t'(1), ones);
        send_division(ones - 1, ones);
        send_division(ones, ones - 1);
        send_division(ones, word_t'(2));
        send_division(top, word_t'(1));
        start_gap();
        send_division(top, top);
        send_division(top, top + 1);
        send_division(ones, top);
        send_division(ones, top + 1);
        send_division(top - 1, top);
        send_division(word_t'(7), word_t'(3));
        send_division(word_t'(3), word_t'(7));
        start_gap();
        send_division(ones, word_t'(3));
        send_division(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_division(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_division(64'h0123_4567_89AB_CDEF, 64'h0000_0001_0000_0000);
        send_division(64'hFEDC_BA98_7654_3210, 64'hFFFF_FFFF);
        send_division(word_t'(1), top);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned waited;

        rst_n       = 1'b0;
        start       = 1'b0;
        dividend    = '0;
        divisor     = '0;

        // single reset at the start, released on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_directed();

        // random part with start gaps, then a back-to-back tail
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 2) == 0)
                start_gap();
            send_random();
        end
        start <= 1'b0;

        // wait for every predicted result, then drain for strays
        waited = 0;
        while (sb.pending() != 0 && waited < WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0d results never arrived", sb.pending());

        $display("ran %0d divisions, %0d by zero, %0d divisor msb set, %0d divisor > dividend",
                 n_requests, n_zero_den, n_top_den, n_small_quo);
        $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
